@@ hdl/qrs_pkg.sv @@
package qrs_pkg;

    localparam int W        = 32;
    localparam int F        = 16;
    localparam int TOL_W    = 16;
    localparam int DTOL_W   = 32;
    localparam int DISC_W   = 2 * W + 2;
    localparam int SQ_W     = DISC_W / 2;
    localparam int REM_W    = SQ_W + 2;
    localparam int NM_W     = SQ_W + 1;
    localparam int DM_W     = W + 1;
    localparam int DV_W     = DM_W + 1;
    localparam int NUMER_W  = NM_W + F + 2;
    localparam int PIPE_LAT = 3 + SQ_W + 1 + NUMER_W + 1;

    localparam logic [DTOL_W-1:0] DISC_TOL_RESET = DTOL_W'(4295);

    localparam logic [1:0] REG_COEF_TOL = 2'd0;
    localparam logic [1:0] REG_DISC_TOL = 2'd1;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;
    localparam logic [1:0] CNT_INF  = 2'd3;

    typedef enum logic [3:0] {
        CLS_NONE,
        CLS_INF,
        CLS_ONE0,
        CLS_LIN,
        CLS_ZC,
        CLS_QUAD,
        CLS_DNEG,
        CLS_DBL,
        CLS_TWO
    } class_t;

    typedef struct packed {
        class_t         cls;
        logic           na;
        logic [W-1:0]   ma;
        logic           nb;
        logic [W-1:0]   mb;
        logic           nc;
        logic [W-1:0]   mc;
    } ctx_t;

    typedef struct packed {
        logic [DISC_W-1:0] x;
        logic [REM_W-1:0]  rem;
        logic [SQ_W-1:0]   root;
    } sq_t;

    typedef struct packed {
        class_t cls;
        logic   q1neg;
        logic   q2neg;
    } dctx_t;

    typedef struct packed {
        logic [NUMER_W-1:0] n1;
        logic [NUMER_W-1:0] n2;
        logic [DV_W-1:0]    r1;
        logic [DV_W-1:0]    r2;
        logic [NUMER_W-1:0] q1;
        logic [NUMER_W-1:0] q2;
        logic [DV_W-1:0]    d;
    } dv_t;

endpackage

@@ hdl/quadratic_root_solver.sv @@
// A result strobes on done once its start transfer has passed every register of the pipeline.
// Throughput: one coefficient set per cycle; busy stays low, as every stage advances each cycle.
// The pipeline depth is set by the 33-cell square root chain and the 52-cell divider chain.
// The receiver cannot stall: each result is present for exactly one cycle.
// Reset clears all pipeline valid bits and restores both tolerance registers.
module quadratic_root_solver
    import qrs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [W-1:0] coef_a,
    input  logic [W-1:0] coef_b,
    input  logic [W-1:0] coef_c,
    output logic         done,
    output logic [1:0]   root_count,
    output logic [W-1:0] root_first,
    output logic [W-1:0] root_second,
    output logic         overflow,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    logic [TOL_W-1:0]  coef_tol_reg;
    logic [DTOL_W-1:0] disc_tol_reg;

    logic              v0_reg;
    ctx_t              c0_reg;
    ctx_t              c0_next;
    logic              v1_reg;
    ctx_t              c1_reg;
    logic [2*W-1:0]    b2_reg;
    logic [2*W-1:0]    ac_reg;
    logic              v2_reg;
    ctx_t              c2_reg;
    ctx_t              c2_next;
    logic [DISC_W-1:0] dmag_reg;
    logic [DISC_W-1:0] dmag_next;
    logic [DISC_W-1:0] b2_ext;
    logic [DISC_W-1:0] ac4;
    logic              dneg;

    logic              sv [0:SQ_W];
    ctx_t              sc [0:SQ_W];
    sq_t               ss [0:SQ_W];

    logic              dvv [0:NUMER_W];
    dctx_t             dc [0:NUMER_W];
    dv_t               dd [0:NUMER_W];
    logic              pv_reg;
    dctx_t             pc_reg;
    dctx_t             pc_next;
    dv_t               pd_reg;
    dv_t               pd_next;

    logic              done_reg;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic [W-1:0]      r1_reg;
    logic [W-1:0]      r1_next;
    logic [W-1:0]      r2_reg;
    logic [W-1:0]      r2_next;
    logic              ovf_reg;
    logic              ovf_next;

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        return v[W-1] ? W'(-v) : v;
    endfunction

    function automatic logic [W:0] sat_word(input logic [NUMER_W-1:0] q, input logic neg);
        logic [NUMER_W-1:0] limit;
        logic [NUMER_W-1:0] m;
        logic               ov;
        limit = neg ? (NUMER_W'(1) << (W - 1)) : ((NUMER_W'(1) << (W - 1)) - NUMER_W'(1));
        ov = q > limit;
        m = ov ? limit : q;
        return {ov, neg ? W'(-m[W-1:0]) : m[W-1:0]};
    endfunction

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_tol_reg <= '0;
            disc_tol_reg <= DISC_TOL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_COEF_TOL)
            begin
                coef_tol_reg <= cfg_data[TOL_W-1:0];
            end
            else if (cfg_index == REG_DISC_TOL)
            begin
                disc_tol_reg <= cfg_data[DTOL_W-1:0];
            end
        end
    end

    always_comb
    begin
        logic za;
        logic zb;
        logic zc;
        c0_next.na = coef_a[W-1];
        c0_next.nb = coef_b[W-1];
        c0_next.nc = coef_c[W-1];
        c0_next.ma = mag_of(coef_a);
        c0_next.mb = mag_of(coef_b);
        c0_next.mc = mag_of(coef_c);
        za = c0_next.ma <= W'(coef_tol_reg);
        zb = c0_next.mb <= W'(coef_tol_reg);
        zc = c0_next.mc <= W'(coef_tol_reg);
        if (za)
        begin
            c0_next.cls = zb ? (zc ? CLS_INF : CLS_NONE) : CLS_LIN;
        end
        else if (zc)
        begin
            c0_next.cls = zb ? CLS_ONE0 : CLS_ZC;
        end
        else
        begin
            c0_next.cls = CLS_QUAD;
        end
    end

    always_comb
    begin
        b2_ext = DISC_W'(b2_reg);
        ac4 = {ac_reg, 2'b00};
        c2_next = c1_reg;
        if (c1_reg.na != c1_reg.nc)
        begin
            dmag_next = b2_ext + ac4;
            dneg = 1'b0;
        end
        else if (b2_ext >= ac4)
        begin
            dmag_next = b2_ext - ac4;
            dneg = 1'b0;
        end
        else
        begin
            dmag_next = ac4 - b2_ext;
            dneg = 1'b1;
        end
        if (c1_reg.cls == CLS_QUAD)
        begin
            if (dneg && dmag_next > DISC_W'(disc_tol_reg))
            begin
                c2_next.cls = CLS_DNEG;
            end
            else if (dmag_next <= DISC_W'(disc_tol_reg))
            begin
                c2_next.cls = CLS_DBL;
            end
            else
            begin
                c2_next.cls = CLS_TWO;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            pv_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start && !busy;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            pv_reg <= sv[SQ_W];
            done_reg <= dvv[NUMER_W];
        end
    end

    always_ff @(posedge clk)
    begin
        c0_reg <= c0_next;
        c1_reg <= c0_reg;
        b2_reg <= c0_reg.mb * c0_reg.mb;
        ac_reg <= c0_reg.ma * c0_reg.mc;
        c2_reg <= c2_next;
        dmag_reg <= dmag_next;
        pc_reg <= pc_next;
        pd_reg <= pd_next;
        count_reg <= count_next;
        r1_reg <= r1_next;
        r2_reg <= r2_next;
        ovf_reg <= ovf_next;
    end

    assign sv[0] = v2_reg;
    assign sc[0] = c2_reg;
    assign ss[0].x = dmag_reg;
    assign ss[0].rem = '0;
    assign ss[0].root = '0;

    for (genvar i = 0; i < SQ_W; i++)
    begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (sv[i]),
            .ctx_in    (sc[i]),
            .sq_in     (ss[i]),
            .valid_out (sv[i+1]),
            .ctx_out   (sc[i+1]),
            .sq_out    (ss[i+1])
        );
    end

    always_comb
    begin
        ctx_t             c;
        logic [SQ_W-1:0]  s;
        logic [NM_W-1:0]  mbx;
        logic [NM_W-1:0]  sx;
        logic [NM_W-1:0]  nm1;
        logic [NM_W-1:0]  nm2;
        logic             n1;
        logic             n2;
        logic [DM_W-1:0]  dm;
        logic             dn;
        c = sc[SQ_W];
        s = ss[SQ_W].root;
        mbx = NM_W'(c.mb);
        sx = NM_W'(s);
        nm1 = mbx;
        nm2 = '0;
        n1 = !c.nb;
        n2 = 1'b0;
        dm = {c.ma, 1'b0};
        dn = c.na;
        unique case (c.cls)
            CLS_LIN:
            begin
                nm1 = NM_W'(c.mc);
                n1 = !c.nc;
                dm = DM_W'(c.mb);
                dn = c.nb;
            end
            CLS_ZC:
            begin
                dm = DM_W'(c.ma);
            end
            CLS_TWO:
            begin
                if (c.nb)
                begin
                    n1 = 1'b0;
                    nm1 = mbx + sx;
                end
                else if (mbx >= sx)
                begin
                    n1 = 1'b1;
                    nm1 = mbx - sx;
                end
                else
                begin
                    n1 = 1'b0;
                    nm1 = sx - mbx;
                end
                if (!c.nb)
                begin
                    n2 = 1'b1;
                    nm2 = mbx + sx;
                end
                else if (mbx >= sx)
                begin
                    n2 = 1'b0;
                    nm2 = mbx - sx;
                end
                else
                begin
                    n2 = 1'b1;
                    nm2 = sx - mbx;
                end
            end
            default:
            begin
            end
        endcase
        pc_next.cls = c.cls;
        pc_next.q1neg = n1 != dn;
        pc_next.q2neg = n2 != dn;
        pd_next.n1 = (NUMER_W'(nm1) << (F + 1)) + NUMER_W'(dm);
        pd_next.n2 = (NUMER_W'(nm2) << (F + 1)) + NUMER_W'(dm);
        pd_next.r1 = '0;
        pd_next.r2 = '0;
        pd_next.q1 = '0;
        pd_next.q2 = '0;
        pd_next.d = {dm, 1'b0};
    end

    assign dvv[0] = pv_reg;
    assign dc[0] = pc_reg;
    assign dd[0] = pd_reg;

    for (genvar j = 0; j < NUMER_W; j++)
    begin : g_div
        qrs_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (dvv[j]),
            .ctx_in    (dc[j]),
            .dv_in     (dd[j]),
            .valid_out (dvv[j+1]),
            .ctx_out   (dc[j+1]),
            .dv_out    (dd[j+1])
        );
    end

    always_comb
    begin
        logic [W:0] w1;
        logic [W:0] w2;
        w1 = sat_word(dd[NUMER_W].q1, dc[NUMER_W].q1neg);
        w2 = sat_word(dd[NUMER_W].q2, dc[NUMER_W].q2neg);
        count_next = CNT_NONE;
        r1_next = '0;
        r2_next = '0;
        ovf_next = 1'b0;
        unique case (dc[NUMER_W].cls)
            CLS_INF:
            begin
                count_next = CNT_INF;
            end
            CLS_ONE0:
            begin
                count_next = CNT_ONE;
            end
            CLS_LIN, CLS_DBL:
            begin
                count_next = CNT_ONE;
                r1_next = w1[W-1:0];
                r2_next = w1[W-1:0];
                ovf_next = w1[W];
            end
            CLS_ZC:
            begin
                count_next = CNT_TWO;
                r1_next = w1[W-1:0];
                ovf_next = w1[W];
            end
            CLS_TWO:
            begin
                count_next = CNT_TWO;
                r1_next = w1[W-1:0];
                r2_next = w2[W-1:0];
                ovf_next = w1[W] || w2[W];
            end
            default:
            begin
            end
        endcase
    end

    assign done = done_reg;
    assign root_count = count_reg;
    assign root_first = r1_reg;
    assign root_second = r2_reg;
    assign overflow = ovf_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##PIPE_LAT done)
        else $error("result did not appear after the pipeline latency");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && root_count == CNT_NONE |-> root_first == '0 && root_second == '0 && !overflow)
        else $error("no-root result carries nonzero data");

    a_inf_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && root_count == CNT_INF |-> root_first == '0 && !overflow)
        else $error("infinite-root result carries data");

    a_one_equal: assert property (@(posedge clk) disable iff (!rst_n)
        done && root_count == CNT_ONE |-> root_first == root_second)
        else $error("single-root result has differing roots");

endmodule

@@ hdl/qrs_sqrt_cell.sv @@
module qrs_sqrt_cell
    import qrs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic valid_in,
    input  ctx_t ctx_in,
    input  sq_t  sq_in,
    output logic valid_out,
    output ctx_t ctx_out,
    output sq_t  sq_out
);

    logic             valid_reg;
    ctx_t             ctx_reg;
    sq_t              sq_reg;
    sq_t              sq_next;
    logic [REM_W+1:0] cand;
    logic [REM_W+1:0] trial;

    always_comb
    begin
        cand = {sq_in.rem, sq_in.x[DISC_W-1 -: 2]};
        trial = (REM_W+2)'({sq_in.root, 2'b01});
        sq_next.x = {sq_in.x[DISC_W-3:0], 2'b00};
        if (cand >= trial)
        begin
            sq_next.rem = REM_W'(cand - trial);
            sq_next.root = {sq_in.root[SQ_W-2:0], 1'b1};
        end
        else
        begin
            sq_next.rem = REM_W'(cand);
            sq_next.root = {sq_in.root[SQ_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg <= ctx_in;
        sq_reg <= sq_next;
    end

    assign valid_out = valid_reg;
    assign ctx_out = ctx_reg;
    assign sq_out = sq_reg;

endmodule

@@ hdl/qrs_div_cell.sv @@
module qrs_div_cell
    import qrs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  valid_in,
    input  dctx_t ctx_in,
    input  dv_t   dv_in,
    output logic  valid_out,
    output dctx_t ctx_out,
    output dv_t   dv_out
);

    logic          valid_reg;
    dctx_t         ctx_reg;
    dv_t           dv_reg;
    dv_t           dv_next;
    logic [DV_W:0] cand1;
    logic [DV_W:0] cand2;

    always_comb
    begin
        dv_next = dv_in;
        dv_next.n1 = {dv_in.n1[NUMER_W-2:0], 1'b0};
        dv_next.n2 = {dv_in.n2[NUMER_W-2:0], 1'b0};
        cand1 = {dv_in.r1, dv_in.n1[NUMER_W-1]};
        cand2 = {dv_in.r2, dv_in.n2[NUMER_W-1]};
        if (cand1 >= {1'b0, dv_in.d})
        begin
            dv_next.r1 = DV_W'(cand1 - {1'b0, dv_in.d});
            dv_next.q1 = {dv_in.q1[NUMER_W-2:0], 1'b1};
        end
        else
        begin
            dv_next.r1 = DV_W'(cand1);
            dv_next.q1 = {dv_in.q1[NUMER_W-2:0], 1'b0};
        end
        if (cand2 >= {1'b0, dv_in.d})
        begin
            dv_next.r2 = DV_W'(cand2 - {1'b0, dv_in.d});
            dv_next.q2 = {dv_in.q2[NUMER_W-2:0], 1'b1};
        end
        else
        begin
            dv_next.r2 = DV_W'(cand2);
            dv_next.q2 = {dv_in.q2[NUMER_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg <= ctx_in;
        dv_reg <= dv_next;
    end

    assign valid_out = valid_reg;
    assign ctx_out = ctx_reg;
    assign dv_out = dv_reg;

endmodule

@@ tb/sv/tb_quadratic_root_solver.sv @@
module tb_quadratic_root_solver;
    import qrs_pkg::*;

    localparam int LATENCY   = 90;
    localparam int WD_LIMIT  = 4000;
    localparam int WIDE_W    = 140;

    typedef struct packed {
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic [W-1:0] c;
    } coef_set_t;

    typedef struct packed {
        logic [1:0]   count;
        logic [W-1:0] first;
        logic [W-1:0] second;
        logic         ovf;
    } roots_t;

    logic         clk;
    logic         rst_n;
    logic         start;
    logic         busy;
    logic [W-1:0] coef_a;
    logic [W-1:0] coef_b;
    logic [W-1:0] coef_c;
    logic         done;
    logic [1:0]   root_count;
    logic [W-1:0] root_first;
    logic [W-1:0] root_second;
    logic         overflow;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;

    coef_set_t    pending_sets[$];
    roots_t       expected_roots[$];
    logic [TOL_W-1:0]  coef_tol;
    logic [DTOL_W-1:0] disc_tol;
    int           mismatches;
    int           idle_pct;
    int           quiet_cycles;
    logic         cfg_req;
    logic [1:0]   cfg_req_index;
    logic [31:0]  cfg_req_data;

    quadratic_root_solver u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
        .done(done), .root_count(root_count), .root_first(root_first),
        .root_second(root_second), .overflow(overflow),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic logic [WIDE_W-1:0] isqrt(input logic [WIDE_W-1:0] x);
        logic [WIDE_W-1:0] res;
        logic [WIDE_W-1:0] bitv;
        logic [WIDE_W-1:0] t;
        res = '0;
        bitv = WIDE_W'(1) << 126;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            t = res + bitv;
            if (x >= t)
            begin
                x = x - t;
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [W-1:0] round_div(input logic nn, input logic [WIDE_W-1:0] nm,
                                               input logic dn, input logic [WIDE_W-1:0] dm,
                                               inout logic ovf);
        logic [WIDE_W-1:0] q;
        logic [WIDE_W-1:0] lim;
        logic neg;
        q = ((nm << (F + 1)) + dm) / (dm << 1);
        neg = nn != dn;
        lim = neg ? (WIDE_W'(1) << (W - 1)) : ((WIDE_W'(1) << (W - 1)) - 1);
        if (q > lim)
        begin
            q = lim;
            ovf = 1'b1;
        end
        return neg ? W'(-q) : W'(q);
    endfunction

    function automatic roots_t solve_roots(input coef_set_t s);
        roots_t r;
        logic na, nb, nc, za, zb, zc, dneg, n1, n2, ovf;
        logic [WIDE_W-1:0] ma, mb, mc, b2, ac4, dmag, sq, m1, m2, den;
        na = s.a[W-1];
        nb = s.b[W-1];
        nc = s.c[W-1];
        ma = na ? WIDE_W'(W'(-s.a)) : WIDE_W'(s.a);
        mb = nb ? WIDE_W'(W'(-s.b)) : WIDE_W'(s.b);
        mc = nc ? WIDE_W'(W'(-s.c)) : WIDE_W'(s.c);
        if (na && s.a == {1'b1, {(W-1){1'b0}}}) ma = WIDE_W'(1) << (W - 1);
        if (nb && s.b == {1'b1, {(W-1){1'b0}}}) mb = WIDE_W'(1) << (W - 1);
        if (nc && s.c == {1'b1, {(W-1){1'b0}}}) mc = WIDE_W'(1) << (W - 1);
        za = ma <= coef_tol;
        zb = mb <= coef_tol;
        zc = mc <= coef_tol;
        ovf = 1'b0;
        r = '0;
        if (za)
        begin
            if (zb)
                r.count = zc ? CNT_INF : CNT_NONE;
            else
            begin
                r.first = round_div(!nc, mc, nb, mb, ovf);
                r.second = r.first;
                r.count = CNT_ONE;
            end
        end
        else if (zc)
        begin
            if (zb)
                r.count = CNT_ONE;
            else
            begin
                r.first = round_div(!nb, mb, na, ma, ovf);
                r.count = CNT_TWO;
            end
        end
        else
        begin
            b2 = mb * mb;
            ac4 = (ma * mc) << 2;
            den = ma << 1;
            if (na != nc)
            begin
                dmag = b2 + ac4;
                dneg = 1'b0;
            end
            else if (b2 >= ac4)
            begin
                dmag = b2 - ac4;
                dneg = 1'b0;
            end
            else
            begin
                dmag = ac4 - b2;
                dneg = 1'b1;
            end
            if (dneg && dmag > disc_tol)
                r.count = CNT_NONE;
            else if (dmag <= disc_tol)
            begin
                r.first = round_div(!nb, mb, na, den, ovf);
                r.second = r.first;
                r.count = CNT_ONE;
            end
            else
            begin
                sq = isqrt(dmag);
                if (nb) begin m1 = mb + sq; n1 = 1'b0; end
                else if (mb >= sq) begin m1 = mb - sq; n1 = 1'b1; end
                else begin m1 = sq - mb; n1 = 1'b0; end
                if (nb) begin
                    if (mb >= sq) begin m2 = mb - sq; n2 = 1'b0; end
                    else begin m2 = sq - mb; n2 = 1'b1; end
                end
                else begin m2 = mb + sq; n2 = 1'b1; end
                r.first = round_div(n1, m1, na, den, ovf);
                r.second = round_div(n2, m2, na, den, ovf);
                r.count = CNT_TWO;
            end
        end
        r.ovf = ovf;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                   input logic [W-1:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            expected_roots.push_back(solve_roots('{coef_a, coef_b, coef_c}));
        if (rst_n && cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_COEF_TOL) coef_tol <= cfg_data[TOL_W-1:0];
            else if (cfg_index == REG_DISC_TOL) disc_tol <= cfg_data;
        end
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (rst_n && !(start && !busy) && ($urandom_range(99) >= idle_pct)
            && pending_sets.size() > 0)
        begin
            start <= 1'b1;
            {coef_a, coef_b, coef_c} <= pending_sets.pop_front();
        end
        else if (rst_n && start && busy)
            start <= 1'b1;
        else if (rst_n && start && !busy && pending_sets.size() > 0
                 && $urandom_range(99) >= idle_pct)
        begin
            start <= 1'b1;
            {coef_a, coef_b, coef_c} <= pending_sets.pop_front();
        end
        else
            start <= 1'b0;
        if (cfg_valid && cfg_ready)
            cfg_valid <= 1'b0;
        else if (cfg_req && !cfg_valid)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_req_index;
            cfg_data <= cfg_req_data;
        end
    end

    always @(posedge clk)
    begin
        roots_t want;
        if (rst_n && done)
        begin
            if (expected_roots.size() == 0)
            begin
                $display("unexpected result transfer");
                mismatches++;
            end
            else
            begin
                want = expected_roots.pop_front();
                if (root_count !== want.count)
                    report_mismatch("root_count", W'(root_count), W'(want.count));
                if (root_first !== want.first)
                    report_mismatch("root_first", root_first, want.first);
                if (root_second !== want.second)
                    report_mismatch("root_second", root_second, want.second);
                if (overflow !== want.ovf)
                    report_mismatch("overflow", W'(overflow), W'(want.ovf));
            end
        end
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= WD_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [W-1:0] rand_coef(input int mode);
        case (mode)
            0: return $urandom();
            1: return W'($signed($urandom_range(2 * 65536 * 16)) - 65536 * 16);
            2: return W'($signed($urandom_range(64)) - 32);
            default: return W'($signed($urandom_range(2 * 65536 * 256)) - 65536 * 256);
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_sets.size() > 0 || start || expected_roots.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_req_index = idx;
        cfg_req_data = val;
        cfg_req = 1'b1;
        @(posedge clk);
        while (!(cfg_valid && cfg_ready)) @(posedge clk);
        cfg_req = 1'b0;
        @(posedge clk);
    endtask

    task automatic push_set(input logic [W-1:0] a, input logic [W-1:0] b,
                            input logic [W-1:0] c);
        pending_sets.push_back('{a, b, c});
    endtask

    localparam logic [W-1:0] ONE  = 32'h0001_0000;
    localparam logic [W-1:0] MAXV = 32'h7fff_ffff;
    localparam logic [W-1:0] MINV = 32'h8000_0000;

    initial
    begin
        int ph;
        int k;
        start = 1'b0;
        coef_a = '0;
        coef_b = '0;
        coef_c = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_COEF_TOL;
        cfg_data = '0;
        cfg_req = 1'b0;
        cfg_req_index = REG_COEF_TOL;
        cfg_req_data = '0;
        coef_tol = '0;
        disc_tol = DISC_TOL_RESET;
        mismatches = 0;
        idle_pct = 0;
        quiet_cycles = 0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_set(0, 0, 0);
        push_set(0, 0, ONE);
        push_set(0, ONE, ONE);
        push_set(0, 32'h0000_0001, MAXV);
        push_set(ONE, ONE, 0);
        push_set(ONE, 0, 0);
        push_set(ONE, 0, ONE);
        push_set(ONE, 32'hfffe_0000, ONE);
        push_set(ONE, 0, 32'hffff_0000);
        push_set(ONE, 32'hfffd_0000, 32'h0002_0000);
        push_set(MAXV, MAXV, MAXV);
        push_set(MINV, MINV, MINV);
        push_set(MINV, MAXV, MINV);
        push_set(32'h0000_0001, MAXV, MINV);
        push_set(32'h0000_0001, MINV, 32'h0000_0001);
        push_set(MAXV, 32'hffff_ffff, 32'h0000_0001);
        push_set(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        push_set(0, MINV, MAXV);
        push_set(MINV, 0, 0);
        push_set(32'h0000_0003, 32'h0000_0004, 32'h0000_0005);
        wait_drained();

        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin write_reg(REG_COEF_TOL, 0); write_reg(REG_DISC_TOL, 0); end
                1: begin write_reg(REG_COEF_TOL, 16'hffff); write_reg(REG_DISC_TOL, 32'hffff_ffff); end
                2: begin write_reg(REG_COEF_TOL, 16); write_reg(REG_DISC_TOL, DISC_TOL_RESET); end
                3: begin write_reg(REG_COEF_TOL, $urandom_range(65535)); write_reg(REG_DISC_TOL, $urandom()); end
                4: begin write_reg(REG_COEF_TOL, 1); write_reg(REG_DISC_TOL, 32'h0010_0000); end
                default: begin write_reg(REG_COEF_TOL, 0); write_reg(REG_DISC_TOL, DISC_TOL_RESET); end
            endcase
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 53;
                2: idle_pct = 21;
                default: idle_pct = 53;
            endcase
            for (k = 0; k < 125; k++)
                push_set(rand_coef($urandom_range(3)), rand_coef($urandom_range(3)),
                         ($urandom_range(7) == 0) ? W'(0) : rand_coef($urandom_range(3)));
            wait_drained();
        end

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/qrs_pkg.sv
hdl/qrs_sqrt_cell.sv
hdl/qrs_div_cell.sv
hdl/quadratic_root_solver.sv
tb/sv/tb_quadratic_root_solver.sv
